FILE: rtl/rlc_pkg.sv
// ----------------------------------------------------------------------------
// rlc_pkg
// Shared types, pattern tables and the line type decision for the reply line
// classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package rlc_pkg;

  typedef logic [7:0] byte_t;

  localparam int unsigned WinDepth  = 9;
  localparam int unsigned NumPats   = 9;
  localparam int unsigned MaxPat    = 10;
  localparam int unsigned PrefixLen = 4;

  typedef enum logic [3:0] {
    LT_STARTUP  = 4'd0,
    LT_STATUS   = 4'd1,
    LT_OK       = 4'd2,
    LT_ERROR    = 4'd3,
    LT_ALARM    = 4'd4,
    LT_LOCKED   = 4'd5,
    LT_HELP     = 4'd6,
    LT_UNLOCKED = 4'd7,
    LT_ENABLED  = 4'd8,
    LT_DISABLED = 4'd9,
    LT_PROBE    = 4'd10,
    LT_PARSER   = 4'd11
  } line_type_e;

  // Control handed down the window chain.
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  localparam byte_t CHAR_LT = 8'h3C;  // '<'
  localparam byte_t CHAR_GT = 8'h3E;  // '>'

  localparam byte_t PREFIX_TEXT [PrefixLen] = '{"G", "r", "b", "l"};

  // Substrings in priority order, first character at index 0, zero padded.
  localparam int unsigned PAT_LEN [NumPats] = '{2, 5, 5, 9, 3, 8, 9, 10, 3};

  localparam byte_t PAT_TEXT [NumPats][MaxPat] = '{
    '{"o", "k", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"e", "r", "r", "o", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"A", "L", "A", "R", "M", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"t", "o", " ", "u", "n", "l", "o", "c", "k", 8'h00},
    '{"H", "L", "P", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"U", "n", "l", "o", "c", "k", "e", "d", 8'h00, 8'h00},
    '{"[", "E", "n", "a", "b", "l", "e", "d", "]", 8'h00},
    '{"[", "D", "i", "s", "a", "b", "l", "e", "d", "]"},
    '{"P", "R", "B", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  function automatic logic [3:0] classify(input logic               startup,
                                          input logic               status,
                                          input logic [NumPats-1:0] seen);
    logic [3:0] res;
    res = LT_PARSER;
    // walk from lowest priority up so the highest-priority seen substring wins
    for (int i = NumPats - 1; i >= 0; i--) begin
      if (seen[i]) begin
        res = LT_OK + 4'(i);
      end
    end
    if (status) begin
      res = LT_STATUS;
    end
    if (startup) begin
      res = LT_STARTUP;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/rlc_cell.sv
// ----------------------------------------------------------------------------
// rlc_cell
// One byte stage of the character window; takes its input byte on shift and zeroes on clear.
// ----------------------------------------------------------------------------
`default_nettype none

module rlc_cell (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  rlc_pkg::cell_ctrl_t ctrl_i,
  input  rlc_pkg::byte_t      byte_i,
  output rlc_pkg::byte_t      byte_o
);

  rlc_pkg::byte_t byte_q, byte_d;

  always_comb begin
    byte_d = byte_q;
    if (ctrl_i.clear) begin
      byte_d = '0;
    end else if (ctrl_i.shift) begin
      byte_d = byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else begin
      byte_q <= byte_d;
    end
  end

  assign byte_o = byte_q;

endmodule

`default_nettype wire

FILE: rtl/rlc_match.sv
// ----------------------------------------------------------------------------
// rlc_match
// Checks which substrings end at the incoming byte, using the window taps.
// ----------------------------------------------------------------------------
`default_nettype none

module rlc_match (
  input  rlc_pkg::byte_t                tap_i [rlc_pkg::MaxPat],
  output logic [rlc_pkg::NumPats-1:0]   hit_o
);

  // tap 0 is the incoming byte, tap k the byte k positions back
  for (genvar i = 0; i < rlc_pkg::NumPats; i++) begin : g_pat
    logic [rlc_pkg::MaxPat-1:0] eq;
    for (genvar k = 0; k < rlc_pkg::MaxPat; k++) begin : g_tap
      if (k < rlc_pkg::PAT_LEN[i]) begin : g_cmp
        localparam int unsigned Idx = rlc_pkg::PAT_LEN[i] - 1 - k;
        assign eq[k] = (tap_i[k] == rlc_pkg::PAT_TEXT[i][Idx]);
      end else begin : g_pad
        assign eq[k] = 1'b1;
      end
    end
    assign hit_o[i] = &eq;
  end

endmodule

`default_nettype wire

FILE: rtl/reply_line_classifier_top.sv
// ----------------------------------------------------------------------------
// reply_line_classifier_top
// Classifies a controller reply line streamed in at most one byte per item.
// ----------------------------------------------------------------------------
// One item is taken every cycle while in_stall_o is low. Bytes shift through
// a chain of nine window cells; every substring compare ends at the incoming
// byte, so a match is known in the same cycle the byte arrives. The type code
// of a line is registered in the main or skid output register when the item
// carrying line_end is accepted. Results sit in a two-entry output buffer, so
// input keeps flowing while one result waits; in_stall_o rises only when both
// entries are held. All line state clears after each line end.
`default_nettype none

module reply_line_classifier_top (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_stall_o,
  input  wire  [7:0] char_code_i,
  input  wire        no_char_i,
  input  wire        line_end_i,
  output logic       out_valid_o,
  input  wire        out_stall_i,
  output logic [3:0] line_type_o
);

  localparam int unsigned CntW = $clog2(rlc_pkg::PrefixLen + 1);

  logic accept, take, fin;
  rlc_pkg::cell_ctrl_t ctrl;
  rlc_pkg::byte_t win [rlc_pkg::WinDepth];
  rlc_pkg::byte_t tap [rlc_pkg::MaxPat];
  logic [rlc_pkg::NumPats-1:0] hit;

  logic [rlc_pkg::NumPats-1:0] seen_q, seen_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic pfx_ok_q, pfx_ok_d;
  logic lt_q, lt_d;
  logic gt_q, gt_d;
  logic [3:0] type_w;

  assign accept = in_valid_i && !in_stall_o;
  assign take   = accept && !no_char_i;
  assign fin    = accept && line_end_i;

  assign ctrl.shift = take;
  assign ctrl.clear = fin;

  for (genvar k = 0; k < rlc_pkg::WinDepth; k++) begin : g_cell
    rlc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .byte_i (tap[k]),
      .byte_o (win[k])
    );
  end

  always_comb begin
    tap[0] = char_code_i;
    for (int k = 1; k < rlc_pkg::MaxPat; k++) begin
      tap[k] = win[k-1];
    end
  end

  rlc_match u_match (
    .tap_i (tap),
    .hit_o (hit)
  );

  // line flags after this item's byte
  always_comb begin
    seen_d   = seen_q;
    cnt_d    = cnt_q;
    pfx_ok_d = pfx_ok_q;
    lt_d     = lt_q;
    gt_d     = gt_q;
    if (take) begin
      seen_d = seen_q | hit;
      if (cnt_q == '0) begin
        lt_d = (char_code_i == rlc_pkg::CHAR_LT);
      end
      if (cnt_q < CntW'(rlc_pkg::PrefixLen)) begin
        if (char_code_i != rlc_pkg::PREFIX_TEXT[cnt_q[$clog2(rlc_pkg::PrefixLen)-1:0]]) begin
          pfx_ok_d = 1'b0;
        end
        cnt_d = cnt_q + 1'b1;
      end
      gt_d = (char_code_i == rlc_pkg::CHAR_GT);
    end
  end

  assign type_w = rlc_pkg::classify(
      pfx_ok_d && (cnt_d >= CntW'(rlc_pkg::PrefixLen)), lt_d && gt_d, seen_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q   <= '0;
      cnt_q    <= '0;
      pfx_ok_q <= 1'b1;
      lt_q     <= 1'b0;
      gt_q     <= 1'b0;
    end else if (fin) begin
      seen_q   <= '0;
      cnt_q    <= '0;
      pfx_ok_q <= 1'b1;
      lt_q     <= 1'b0;
      gt_q     <= 1'b0;
    end else begin
      seen_q   <= seen_d;
      cnt_q    <= cnt_d;
      pfx_ok_q <= pfx_ok_d;
      lt_q     <= lt_d;
      gt_q     <= gt_d;
    end
  end

  // two-entry output buffer: main register plus skid register
  logic       out_vld_q, out_vld_d;
  logic       skid_vld_q, skid_vld_d;
  logic [3:0] out_q, out_d;
  logic [3:0] skid_q, skid_d;
  logic       pop;

  assign pop = out_vld_q && !out_stall_i;

  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    out_d      = out_q;
    skid_d     = skid_q;
    if (skid_vld_q) begin
      if (pop) begin
        out_d      = skid_q;
        skid_vld_d = 1'b0;
      end
    end else if (fin) begin
      if (!out_vld_q || pop) begin
        out_d     = type_w;
        out_vld_d = 1'b1;
      end else begin
        skid_d     = type_w;
        skid_vld_d = 1'b1;
      end
    end else if (pop) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign in_stall_o  = skid_vld_q;
  assign out_valid_o = out_vld_q;
  assign line_type_o = out_q;

endmodule

`default_nettype wire

FILE: rtl/rlc_checker.sv
// ----------------------------------------------------------------------------
// rlc_checker
// Port-level checks on the reply line classifier, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rlc_checker (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       in_valid_i,
  input wire       in_stall_o,
  input wire       line_end_i,
  input wire       out_valid_o,
  input wire       out_stall_i,
  input wire [3:0] line_type_o
);

  // a held result stays until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(line_type_o))
    else $error("result dropped or changed while stalled");

  a_type_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> line_type_o <= 4'd11)
    else $error("line type out of range");

  // input only stalls when a result is already waiting
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // an item without line end never creates a result
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !line_end_i && !out_valid_o |=> !out_valid_o)
    else $error("result without line end");

  // a line end into an empty output shows up next cycle
  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && line_end_i && !out_valid_o |=> out_valid_o)
    else $error("line end produced no result");

endmodule

bind reply_line_classifier_top rlc_checker u_rlc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .line_end_i  (line_end_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .line_type_o (line_type_o)
);

`default_nettype wire
